/* rtl/lkvc_pkg.sv */
// Shared constants for the LRU key-value cache.
// Used by lru_key_value_cache; no dependencies of its own.
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES_DEFAULT = 16;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // Configuration port geometry.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  // Request operations.
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

endpackage

`default_nettype wire

/* rtl/lkvc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/lru_key_value_cache.sv */
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lkvc_pkg and three lkvc_ram instances (tags, values, ranks).
//
// Usage:
//   Requests enter on in_valid/in_stall with mode, lookup_key and store_value.
//   A get returns one result on out_valid/out_stall (hit, read_value); a put
//   returns nothing. read_value is zero on a miss.
//   Each request is handled alone. A shared comparator sweeps the tag and rank
//   memories one entry per cycle: one sweep finds the key, a free slot and the
//   least recent entry, and a second sweep reorders the ranks. A get that
//   misses skips the second sweep and goes straight to the result; a hit runs
//   it and a commit step before the result, and a put runs it and a commit
//   step before the next request is let in.
//   The result sits in an output register; a new request is accepted while it
//   waits. If the receiver stalls and a new get finishes, that get holds in its
//   final step until the output register frees.
//   The user must write the capacity register (APB, byte address 0) only while
//   idle; the block itself does not enforce it. Reset clears all valid bits,
//   the entry count and sets capacity to 16; no memory clearing pass is needed.
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,

  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              mode,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0]   lookup_key,
  input  wire logic signed [lkvc_pkg::VALUE_W-1:0] store_value,

  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   hit,
  output logic signed [lkvc_pkg::VALUE_W-1:0]      read_value,

  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lkvc_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [lkvc_pkg::PDATA_W-1:0]        pwdata,
  output logic      [lkvc_pkg::PDATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;
  localparam logic [CW-1:0] CNT_N = CW'(ENTRIES);
  localparam logic [EW-1:0] EXT_N = EW'(ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_UPDATE = 6'b001000,
    S_COMMIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [lkvc_pkg::CAP_W-1:0] capacity_in_use;
  logic [ENTRIES-1:0]         valid;
  logic [CW-1:0]              live_count;

  // Latched request.
  logic                        req_mode;
  logic [lkvc_pkg::KEY_W-1:0]   req_key;
  logic [lkvc_pkg::VALUE_W-1:0] req_val;

  // Sweep counter and the index whose read data is arriving this cycle.
  logic [CW-1:0] cnt;
  logic          lag_vld;
  logic [IW-1:0] lag_idx;

  // Search results.
  logic          match_found, free_found, lru_found;
  logic [IW-1:0] match_idx, free_idx, lru_idx;
  logic [RW-1:0] match_rank, lru_rank;

  // Chosen slot for the reorder sweep.
  logic          inc_all, do_new, res_hit;
  logic [IW-1:0] tgt_idx;
  logic [RW-1:0] tgt_rank;

  logic [lkvc_pkg::KEY_W-1:0]   tag_q;
  logic [lkvc_pkg::VALUE_W-1:0] data_q;
  logic [RW-1:0]                rank_q;
  logic [IW-1:0]                sweep_addr;
  logic                         rank_we;
  logic [RW-1:0]                rank_wdata;
  logic                         entry_we;

  logic          accept, cfg_write, lag_live, out_load, room;
  logic [EW-1:0] cap_eff;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == lkvc_pkg::REG_CAPACITY);
  assign prdata    = (paddr[2] == lkvc_pkg::REG_CAPACITY) ?
                     lkvc_pkg::PDATA_W'(capacity_in_use) : '0;

  assign sweep_addr = (cnt < CNT_N) ? cnt[IW-1:0] : '0;
  assign lag_live   = valid[lag_idx];
  assign out_load   = (state == S_DONE) && (!out_valid || !out_stall);
  assign entry_we   = (state == S_COMMIT) && (req_mode == lkvc_pkg::MODE_PUT);

  // Capacity clamped to the range 1 .. ENTRIES.
  always_comb begin
    cap_eff = EW'(capacity_in_use);
    if (cap_eff == '0) begin
      cap_eff = EW'(1);
    end else if (cap_eff > EXT_N) begin
      cap_eff = EXT_N;
    end
  end
  assign room = EW'(live_count) < cap_eff;

  // Rank rewrite: target to rank 0, younger live ones (all on insert) age by one.
  always_comb begin
    rank_we    = 1'b0;
    rank_wdata = '0;
    if (state == S_UPDATE && lag_vld) begin
      if (lag_idx == tgt_idx) begin
        rank_we = 1'b1;
      end else if (lag_live && (inc_all || rank_q < tgt_rank)) begin
        rank_we    = 1'b1;
        rank_wdata = rank_q + RW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (cnt == CNT_N) state_next = S_DECIDE;
      S_DECIDE: begin
        if (!match_found && req_mode == lkvc_pkg::MODE_GET) begin
          state_next = S_DONE;
        end else begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: if (cnt == CNT_N) state_next = S_COMMIT;
      S_COMMIT: begin
        if (req_mode == lkvc_pkg::MODE_GET) begin
          state_next = S_DONE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DONE:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      capacity_in_use <= lkvc_pkg::CAPACITY_RESET;
      valid           <= '0;
      live_count      <= '0;
      cnt             <= '0;
      lag_vld         <= 1'b0;
      match_found     <= 1'b0;
      free_found      <= 1'b0;
      lru_found       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        capacity_in_use <= pwdata[lkvc_pkg::CAP_W-1:0];
      end

      if (state == S_IDLE || state == S_DECIDE) begin
        cnt     <= '0;
        lag_vld <= 1'b0;
      end else if (state == S_SCAN || state == S_UPDATE) begin
        lag_vld <= (cnt < CNT_N);
        if (cnt < CNT_N) begin
          cnt <= cnt + CW'(1);
        end
      end

      if (accept) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
        lru_found   <= 1'b0;
      end else if (state == S_SCAN && lag_vld) begin
        if (lag_live && tag_q == req_key) begin
          match_found <= 1'b1;
        end
        if (!lag_live) begin
          free_found <= 1'b1;
        end
        if (lag_live) begin
          lru_found <= 1'b1;
        end
      end

      if (state == S_COMMIT && entry_we && do_new) begin
        valid[tgt_idx] <= 1'b1;
        live_count     <= live_count + CW'(1);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    lag_idx <= sweep_addr;
    if (accept) begin
      req_mode <= mode;
      req_key  <= lookup_key;
      req_val  <= store_value;
    end
    if (state == S_SCAN && lag_vld) begin
      if (lag_live && tag_q == req_key && !match_found) begin
        match_idx  <= lag_idx;
        match_rank <= rank_q;
      end
      if (!lag_live && !free_found) begin
        free_idx <= lag_idx;
      end
      if (lag_live && (!lru_found || rank_q > lru_rank)) begin
        lru_idx  <= lag_idx;
        lru_rank <= rank_q;
      end
    end
    if (state == S_DECIDE) begin
      res_hit <= match_found;
      if (match_found) begin
        tgt_idx  <= match_idx;
        tgt_rank <= match_rank;
        inc_all  <= 1'b0;
        do_new   <= 1'b0;
      end else if (room && free_found) begin
        tgt_idx  <= free_idx;
        tgt_rank <= '0;
        inc_all  <= 1'b1;
        do_new   <= 1'b1;
      end else begin
        tgt_idx  <= lru_idx;
        tgt_rank <= lru_rank;
        inc_all  <= 1'b0;
        do_new   <= 1'b0;
      end
    end
    if (out_load) begin
      hit        <= res_hit;
      read_value <= res_hit ? data_q : '0;
    end
  end

  lkvc_ram #(.WIDTH(lkvc_pkg::KEY_W), .DEPTH(ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (tgt_idx),
    .wdata (req_key),
    .raddr (sweep_addr),
    .rdata (tag_q)
  );

  lkvc_ram #(.WIDTH(lkvc_pkg::VALUE_W), .DEPTH(ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (tgt_idx),
    .wdata (req_val),
    .raddr (tgt_idx),
    .rdata (data_q)
  );

  lkvc_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (lag_idx),
    .wdata (rank_wdata),
    .raddr (sweep_addr),
    .rdata (rank_q)
  );

  // The entry count always matches the number of valid entries.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == live_count)
    else $error("live_count disagrees with valid bits");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    live_count <= CNT_N)
    else $error("live_count above ENTRIES");

  // A result only appears after a get has finished its final step.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result produced outside the final step");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == '0)
    else $error("miss with nonzero read_value");

  // An insert into a free slot only happens when there is room under the capacity.
  a_insert_has_room: assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT && entry_we && do_new |-> room && !valid[tgt_idx])
    else $error("insert without room or into a live slot");

endmodule

`default_nettype wire

/* sim/lkvc_checker.sv */
// Scoreboard for lru_key_value_cache: mirrors tags, values and recency ranks,
// and checks every lookup result against the mirror in request order.
// Depends on lkvc_pkg; instantiated beside the cache by tb.
module lkvc_checker #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                mode,
  input  logic signed [lkvc_pkg::KEY_W-1:0]   lookup_key,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] store_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                hit,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] read_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkvc_pkg::PADDR_W-1:0]        paddr,
  input  logic [lkvc_pkg::PDATA_W-1:0]        pwdata,
  input  logic                                pready,
  output int                                  fail_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
  } lookup_result_t;

  logic [KEY_W-1:0]   tag_mirror   [ENTRIES];
  logic [VALUE_W-1:0] data_mirror  [ENTRIES];
  logic               valid_mirror [ENTRIES];
  logic [RANK_W-1:0]  rank_mirror  [ENTRIES];
  logic [CAP_W-1:0]   live_entries;
  logic [CAP_W-1:0]   capacity;
  lookup_result_t     expected_lookups[$];

  task automatic report_mismatch(string msg);
    $display("%0t ns lkvc_checker: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int effective_capacity();
    if (capacity == '0) return 1;
    if (int'(capacity) > ENTRIES) return ENTRIES;
    return int'(capacity);
  endfunction

  // Entries that were more recent than slot s age by one; s becomes rank 0.
  function automatic void make_most_recent(int s);
    logic [RANK_W-1:0] old_rank;
    int i;
    old_rank = rank_mirror[s];
    for (i = 0; i < ENTRIES; i++)
      if (valid_mirror[i] && i != s && rank_mirror[i] < old_rank)
        rank_mirror[i] = rank_mirror[i] + 1'b1;
    rank_mirror[s] = '0;
  endfunction

  function automatic void lookup_or_store(logic md, logic [KEY_W-1:0] key,
                                          logic [VALUE_W-1:0] val);
    int found, free_slot, oldest, i;
    lookup_result_t res;
    found = -1;
    free_slot = -1;
    oldest = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (valid_mirror[i] && tag_mirror[i] == key && found < 0) found = i;
      if (!valid_mirror[i] && free_slot < 0) free_slot = i;
      if (valid_mirror[i] && (oldest < 0 || rank_mirror[i] > rank_mirror[oldest]))
        oldest = i;
    end
    if (md == MODE_GET) begin
      res.hit = (found >= 0);
      res.value = '0;
      if (found >= 0) begin
        res.value = data_mirror[found];
        make_most_recent(found);
      end
      expected_lookups.push_back(res);
    end else if (found >= 0) begin
      data_mirror[found] = val;
      make_most_recent(found);
    end else if (int'(live_entries) < effective_capacity() && free_slot >= 0) begin
      for (i = 0; i < ENTRIES; i++)
        if (valid_mirror[i]) rank_mirror[i] = rank_mirror[i] + 1'b1;
      valid_mirror[free_slot] = 1'b1;
      tag_mirror[free_slot] = key;
      data_mirror[free_slot] = val;
      rank_mirror[free_slot] = '0;
      live_entries = live_entries + 1'b1;
    end else begin
      // Full, or capacity lowered below the live count: replace in place.
      tag_mirror[oldest] = key;
      data_mirror[oldest] = val;
      make_most_recent(oldest);
    end
  endfunction

  always @(posedge clk) begin : watch
    lookup_result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < ENTRIES; i++) begin
        valid_mirror[i] = 1'b0;
        rank_mirror[i] = '0;
      end
      live_entries = '0;
      capacity = CAPACITY_RESET;
      expected_lookups.delete();
    end else begin
      // A result leaving at this edge always belongs to an older request.
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch($sformatf("result with no lookup waiting: hit %0b value %0d",
                                    hit, read_value));
        end else begin
          want = expected_lookups.pop_front();
          if (hit !== want.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", hit, want.hit));
          if (read_value !== want.value)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      read_value, $signed(want.value)));
        end
      end
      if (in_valid && !in_stall) lookup_or_store(mode, lookup_key, store_value);
      if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
        capacity = pwdata[CAP_W-1:0];
    end
    pending = expected_lookups.size();
  end

endmodule

/* sim/tb.sv */
// Top-level testbench for lru_key_value_cache: clock, reset, request and
// register stimulus, receiver stalls and the verdict.
// Depends on lkvc_pkg, the cache RTL and lkvc_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int ENTRIES = ENTRIES_DEFAULT;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 10;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 139;
  localparam int PRESSURE_PHASE = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE = 24;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      mode;
  logic signed [KEY_W-1:0]   lookup_key;
  logic signed [VALUE_W-1:0] store_value;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      hit;
  logic signed [VALUE_W-1:0] read_value;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int phase_num = -1;
  int hold_left = 0;
  bit hold_done = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [CAP_W-1:0] cap_plan [PHASES] =
    '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd0, 5'd16, 5'd5, 5'd12};

  lru_key_value_cache #(.ENTRIES(ENTRIES)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .lookup_key(lookup_key), .store_value(store_value),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .read_value(read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lkvc_checker #(.ENTRIES(ENTRIES)) i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .lookup_key(lookup_key), .store_value(store_value),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .read_value(read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off so the cache backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (phase_num == PRESSURE_PHASE && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  task automatic send_request(logic md, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    lookup_key <= k;
    store_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // A put gives no result, so the cache may still be busy once nothing is
  // pending; let a full request time pass as well.
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= (PDATA_W'($urandom()) & ~PDATA_W'(5'h1F)) | PDATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_random_phase(int items, logic [CAP_W-1:0] cap);
    int span, n;
    logic md;
    logic [KEY_W-1:0] k;
    // Draw keys mostly from a pool a little larger than the capacity in use,
    // so that hits, updates and evictions all stay frequent.
    span = (cap == '0) ? 4 : ((int'(cap) > ENTRIES) ? ENTRIES + 3 : int'(cap) + 3);
    for (n = 0; n < items; n++) begin
      md = ($urandom_range(0, 1) == 1) ? MODE_PUT : MODE_GET;
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, span)] : $urandom();
      send_request(md, k, $urandom());
    end
  endtask

  initial begin : stimulus
    int p;
    in_valid <= 1'b0;
    mode <= MODE_GET;
    lookup_key <= '0;
    store_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst <= 1'b1;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (p = 4; p < POOL_SIZE; p++) key_pool[p] = $urandom();
    tx_idle_pct = 21;
    rx_stall_pct = 80;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Capacity zero acts as one: the second insert replaces the first.
    write_capacity(5'd0);
    send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    wait_until_quiet();

    // Capacity above the entry count saturates; fill, update and miss.
    write_capacity(5'd31);
    send_request(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(MODE_GET, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
    send_request(MODE_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_GET, 32'h0000_0005, 32'h0000_0000);
    wait_until_quiet();

    // Capacity below the live count: inserts overwrite the least recent entry.
    write_capacity(5'd2);
    send_request(MODE_PUT, 32'h0000_0064, 32'h5A5A_5A5A);
    send_request(MODE_GET, 32'h0000_0064, 32'h0000_0000);
    send_request(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);

    for (p = 0; p < PHASES; p++) begin
      wait_until_quiet();
      if (p == 3) begin
        tx_idle_pct = 80;
        rx_stall_pct = 21;
      end else if (p == PRESSURE_PHASE) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      write_capacity(cap_plan[p]);
      phase_num = p;
      run_random_phase(ITEMS_PER_PHASE, cap_plan[p]);
    end
    wait_until_quiet();

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
